// ----- rtl/sbre_pkg.sv -----
// ----------------------------------------------------------------------------
// Shadow bitmap range engine package
// Field widths, command codes, the queue entry type and small helpers.
// ----------------------------------------------------------------------------
package sbre_pkg;

   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 15;
   localparam int LEN_W    = 13;
   localparam int COUNT_W  = 13;
   localparam int SIDX_W   = ADDR_W - 3;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_MARK   = 2'd0;
   localparam cmd_type CMD_UNMARK = 2'd1;
   localparam cmd_type CMD_COUNT  = 2'd2;

   // One classified request as it waits between the front and the back.
   typedef struct packed {
      cmd_type           cmd;
      logic              noop;
      logic              status;
      logic [SIDX_W-1:0] first_idx;
      logic [SIDX_W-1:0] last_idx;
      logic [7:0]        first_mask;
      logic [7:0]        last_mask;
   } item_type;

   function automatic logic [3:0] popcount8(input logic [7:0] value);
      logic [3:0] total;
      total = 4'd0;
      for (int i = 0; i < 8; i++) begin
         total = total + 4'(value[i]);
      end
      return total;
   endfunction

endpackage

// ----- rtl/sbre_channels.sv -----
// ----------------------------------------------------------------------------
// Shadow bitmap range engine channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface sbre_req_if;
   import sbre_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] start_address;
   logic [LEN_W-1:0]  length;

   modport source (output valid, output command, output start_address, output length,
                   input ready);
   modport sink   (input valid, input command, input start_address, input length,
                   output ready);
endinterface

interface sbre_rsp_if;
   import sbre_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] set_count;
   logic               status;

   modport source (output valid, output set_count, output status, input ready);
   modport sink   (input valid, input set_count, input status, output ready);
endinterface

// ----- rtl/sbre_front.sv -----
// ----------------------------------------------------------------------------
// Shadow bitmap range engine front end
// Accepts requests, checks the range and turns it into shadow byte indexes
// and edge masks for the back end.
// ----------------------------------------------------------------------------
module sbre_front #(
   parameter int SHADOW_BYTES = 4096,
   parameter int MAX_LENGTH   = 4096
) (
   sbre_req_if.sink          req,
   input  logic              clear_busy,
   input  logic              push_ready,
   output logic              push_valid,
   output sbre_pkg::item_type push_item
);
   import sbre_pkg::*;

   localparam logic [31:0] LIMIT   = 32'(SHADOW_BYTES) * 32'd8;
   localparam logic [31:0] MAX_LEN = 32'(MAX_LENGTH);

   logic [ADDR_W:0] end_sum;
   logic [ADDR_W:0] last_addr;
   logic            zero_len;
   logic            bad_cmd;
   logic            reject;

   assign req.ready  = push_ready && !clear_busy;
   assign push_valid = req.valid && !clear_busy;

   always_comb begin
      end_sum   = {1'b0, req.start_address} + (ADDR_W+1)'(req.length);
      last_addr = end_sum - (ADDR_W+1)'(1);
      zero_len  = (req.length == '0);
      bad_cmd   = (req.command != CMD_MARK) && (req.command != CMD_UNMARK)
                  && (req.command != CMD_COUNT);
      reject    = !zero_len && !bad_cmd
                  && ((32'(req.length) > MAX_LEN) || (32'(end_sum) > LIMIT));

      push_item.cmd        = req.command;
      push_item.noop       = zero_len || bad_cmd || reject;
      push_item.status     = reject;
      push_item.first_idx  = req.start_address[ADDR_W-1:3];
      push_item.last_idx   = last_addr[ADDR_W-1:3];
      push_item.first_mask = 8'hFF << req.start_address[2:0];
      push_item.last_mask  = 8'hFF >> (3'd7 - last_addr[2:0]);
   end

endmodule

// ----- rtl/sbre_queue.sv -----
// ----------------------------------------------------------------------------
// Shadow bitmap range engine queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module sbre_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  sbre_pkg::item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output sbre_pkg::item_type pop_item,
   input  logic               pop_ready,
   output logic [$clog2(sbre_pkg::QUEUE_DEPTH+1)-1:0] fill
);
   import sbre_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign fill       = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/sbre_back.sv -----
// ----------------------------------------------------------------------------
// Shadow bitmap range engine back end
// Holds the shadow bitmap, clears it after reset, walks each range one
// shadow byte per cycle and registers the response.
// ----------------------------------------------------------------------------
module sbre_back #(
   parameter int SHADOW_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  sbre_pkg::item_type pop_item,
   output logic               pop_ready,
   output logic               clear_busy,
   sbre_rsp_if.source         rsp
);
   import sbre_pkg::*;

   localparam int IDX_W = (SHADOW_BYTES > 1) ? $clog2(SHADOW_BYTES) : 1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   item_type           job_ff, job_in;
   logic [SIDX_W-1:0]  cur_ff, cur_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_status_ff, rsp_status_in;

   logic [7:0]         shadow_ff [SHADOW_BYTES];
   logic [7:0]         rdata_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [7:0]         wr_data;

   logic               out_free;
   logic [7:0]         byte_mask;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign clear_busy = (state_ff == ST_CLEAR);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.set_count = rsp_count_ff;
   assign rsp.status    = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      job_in        = job_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      pop_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = IDX_W'(cur_ff);
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(cur_ff);
      wr_data       = rdata_ff;

      byte_mask = ((cur_ff == job_ff.first_idx) ? job_ff.first_mask : 8'hFF)
                  & ((cur_ff == job_ff.last_idx) ? job_ff.last_mask : 8'hFF);

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'h00;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(SHADOW_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // A request that touches nothing answers at once; others start
            // with a read of their first shadow byte.
            if (pop_valid) begin
               if (pop_item.noop) begin
                  if (out_free) begin
                     pop_ready     = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_count_in  = '0;
                     rsp_status_in = pop_item.status;
                  end
               end else begin
                  pop_ready = 1'b1;
                  job_in    = pop_item;
                  cur_in    = pop_item.first_idx;
                  cnt_in    = '0;
                  rd_en     = 1'b1;
                  rd_addr   = IDX_W'(pop_item.first_idx);
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // The byte read last cycle is written back, or counted for a count, while the next one is read.
            if (job_ff.cmd == CMD_COUNT) begin
               cnt_in = cnt_ff + COUNT_W'(popcount8(rdata_ff & byte_mask));
            end else begin
               wr_en   = 1'b1;
               wr_data = (job_ff.cmd == CMD_MARK) ? (rdata_ff | byte_mask)
                                                  : (rdata_ff & ~byte_mask);
            end
            if (cur_ff == job_ff.last_idx) begin
               state_in = ST_DONE;
            end else begin
               cur_in  = cur_ff + SIDX_W'(1);
               rd_en   = 1'b1;
               rd_addr = IDX_W'(cur_ff + SIDX_W'(1));
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = (job_ff.cmd == CMD_COUNT) ? cnt_ff : '0;
               rsp_status_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= shadow_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         shadow_ff[wr_addr] <= wr_data;
      end
   end

endmodule

// ----- rtl/shadow_bitmap_range_engine.sv -----
// A rejected, empty or unknown request responds without a walk. Requests wait in a queue
// ahead of the back end, so a new one can be accepted while an earlier one is walked.
// The back end walks each range with a single read-modify-write pass over the
// bitmap memory, one shadow byte per cycle.
// Reset: synchronous; afterwards a clearing pass zeroes the bitmap while
// req_chan.ready stays low.
// ----------------------------------------------------------------------------
// Shadow bitmap range engine
// Marks, unmarks and counts allocation bits of a byte range in a shadow bitmap.
// ----------------------------------------------------------------------------
module shadow_bitmap_range_engine #(
   parameter int SHADOW_BYTES = 4096,
   parameter int MAX_LENGTH   = 4096
) (
   input  logic       clock,
   input  logic       reset,
   sbre_req_if.sink   req_chan,
   sbre_rsp_if.source rsp_chan
);
   import sbre_pkg::*;

   logic     clear_busy;
   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_fill;

   sbre_front #(
      .SHADOW_BYTES (SHADOW_BYTES),
      .MAX_LENGTH   (MAX_LENGTH)
   ) u_front (
      .req        (req_chan),
      .clear_busy (clear_busy),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   sbre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .fill       (q_fill)
   );

   sbre_back #(
      .SHADOW_BYTES (SHADOW_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .clear_busy (clear_busy),
      .rsp        (rsp_chan)
   );

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !(req_chan.valid && req_chan.ready))
      else $error("request accepted during the clearing pass");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> clear_busy)
      else $error("clearing pass did not start after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_fill <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) && !(push_valid && push_ready
       && q_fill == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
      else $error("queue overflow");

   a_reject_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |-> (rsp_chan.set_count == '0))
      else $error("rejected range reported a nonzero count");
`endif

endmodule
